>>> hw/rtl/stack_machine_evaluator_unit_assert.svh
// assertion macros used by stack_machine_evaluator_unit
`ifndef STACK_MACHINE_EVALUATOR_UNIT_ASSERT_SVH
`define STACK_MACHINE_EVALUATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// property checked on every rising clock edge outside reset
`define SMEV_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// signal held low while reset is asserted
`define SMEV_ASSERT_LOW_IN_RST(lbl, clk, rstn, sig, msg) \
	lbl: assert property (@(posedge clk) !rstn |-> !(sig)) else $error(msg);

`else

`define SMEV_ASSERT(lbl, clk, rstn, prop, msg)
`define SMEV_ASSERT_LOW_IN_RST(lbl, clk, rstn, sig, msg)

`endif

`endif

>>> hw/rtl/smev_pkg.sv
`default_nettype none
package smev_pkg;

	localparam int DATA_W = 32;
	localparam int LIT_W  = 24;
	localparam int OP_W   = 8;
	localparam int ST_W   = 3;

	localparam logic [OP_W-1:0] OP_LIT = 8'd0;
	localparam logic [OP_W-1:0] OP_ADD = 8'd1;
	localparam logic [OP_W-1:0] OP_SUB = 8'd2;
	localparam logic [OP_W-1:0] OP_MUL = 8'd3;
	localparam logic [OP_W-1:0] OP_DIV = 8'd4;
	localparam logic [OP_W-1:0] OP_MOD = 8'd5;
	localparam logic [OP_W-1:0] OP_END = 8'd6;

	localparam logic [ST_W-1:0] ST_OK    = 3'd0;
	localparam logic [ST_W-1:0] ST_UNDER = 3'd1;
	localparam logic [ST_W-1:0] ST_OVER  = 3'd2;
	localparam logic [ST_W-1:0] ST_DIVZ  = 3'd3;
	localparam logic [ST_W-1:0] ST_BADOP = 3'd4;

	typedef enum logic [2:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV,
		ALU_MOD
	} alu_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_CALC,
		S_WAIT
	} state_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_rsp_t;

endpackage
`default_nettype wire

>>> hw/rtl/stack_machine_evaluator_unit.sv
`default_nettype none
// channel | signals                              | dir | beat
// in      | in_valid in_ready op literal          | in  | one instruction
// out     | out_valid out_ready top_value status  | out | one result per instruction
//         | done_res                              |     |
//
// push, end and error beats pass from accept through the exec and wait states into the output register
// zero divisor is caught in the read state after the stack read, then goes through wait to the output register
// add, sub, mul, div and mod: decode and stack read, then the bit-serial alu, whose
// finish step registers its result with a sign fix for div and mod, then one step each
// to latch the alu result and to move it into the output register
// arst_n clears the stack count, the fsm and the output valid; no clearing pass
// a stalled output holds the fsm in its wait state; the next instruction is
// taken once the result has moved into the output register
module stack_machine_evaluator_unit #(
	parameter int STACK_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [smev_pkg::OP_W-1:0]     op,
	input  logic [smev_pkg::LIT_W-1:0]    literal,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [smev_pkg::DATA_W-1:0] top_value,
	output logic [smev_pkg::ST_W-1:0]     status,
	output logic                          done_res
);
	import smev_pkg::*;

`include "stack_machine_evaluator_unit_assert.svh"

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	// top of stack lives in top_q; the memory holds the entries below it
	logic [DATA_W-1:0] mem [STACK_DEPTH];
	logic [DATA_W-1:0] rd_q, top_q;
	logic [CW-1:0]     count_q;
	state_t            state_q, state_d;

	logic [OP_W-1:0]   op_q;
	logic [LIT_W-1:0]  lit_q;

	logic [DATA_W-1:0] res_top_q;
	logic [ST_W-1:0]   res_st_q;
	logic              res_done_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_top_q;
	logic [ST_W-1:0]   out_st_q;
	logic              out_done_q;

	logic              accept, out_free;
	logic [CW-1:0]     cnt_m1, cnt_m2;
	logic [DATA_W-1:0] cur_top, lit_ext;
	logic              is_divmod;

	// control decoded by the fsm
	logic              mem_we, mem_re, top_we, cnt_we, res_we, out_load;
	logic [DATA_W-1:0] top_d, res_top_d;
	logic [CW-1:0]     cnt_d;
	logic [ST_W-1:0]   res_st_d;
	logic              res_done_d;

	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;
	logic [DATA_W-1:0] alu_res;

	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign cnt_m1    = count_q - CW'(1);
	assign cnt_m2    = count_q - CW'(2);
	assign cur_top   = (count_q == '0) ? '0 : top_q;
	assign lit_ext   = {{(DATA_W - LIT_W){1'b0}}, lit_q};
	assign is_divmod = (op_q == OP_DIV) || (op_q == OP_MOD);
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		state_d    = state_q;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		top_we     = 1'b0;
		cnt_we     = 1'b0;
		res_we     = 1'b0;
		out_load   = 1'b0;
		top_d      = top_q;
		cnt_d      = count_q;
		res_top_d  = cur_top;
		res_st_d   = ST_OK;
		res_done_d = 1'b0;
		alu_req.start = 1'b0;
		unique case (op_q)
			OP_ADD:  alu_req.op = ALU_ADD;
			OP_SUB:  alu_req.op = ALU_SUB;
			OP_MUL:  alu_req.op = ALU_MUL;
			OP_DIV:  alu_req.op = ALU_DIV;
			default: alu_req.op = ALU_MOD;
		endcase
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_EXEC;
			end
			S_EXEC: begin
				res_we  = 1'b1;
				state_d = S_WAIT;
				case (op_q)
					OP_LIT: begin
						if (count_q == CW'(STACK_DEPTH)) begin
							res_st_d = ST_OVER;
						end else begin
							// old top drops into memory
							mem_we    = (count_q != '0);
							top_we    = 1'b1;
							top_d     = lit_ext;
							cnt_we    = 1'b1;
							cnt_d     = count_q + CW'(1);
							res_top_d = lit_ext;
						end
					end
					OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
						if (count_q < CW'(2)) begin
							res_st_d = ST_UNDER;
						end else begin
							res_we  = 1'b0;
							mem_re  = 1'b1;
							state_d = S_READ;
						end
					end
					OP_END: begin
						if (count_q == '0) begin
							res_st_d = ST_UNDER;
						end else begin
							res_done_d = 1'b1;
							cnt_we     = 1'b1;
							cnt_d      = '0;
						end
					end
					default: res_st_d = ST_BADOP;
				endcase
			end
			S_READ: begin
				if (is_divmod && rd_q == '0) begin
					res_we   = 1'b1;
					res_st_d = ST_DIVZ;
					state_d  = S_WAIT;
				end else begin
					alu_req.start = 1'b1;
					state_d       = S_CALC;
				end
			end
			S_CALC: begin
				if (alu_rsp.done) begin
					top_we    = 1'b1;
					top_d     = alu_res;
					cnt_we    = 1'b1;
					cnt_d     = cnt_m1;
					res_we    = 1'b1;
					res_top_d = alu_res;
					state_d   = S_WAIT;
				end
			end
			S_WAIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_we) count_q <= cnt_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op;
			lit_q <= literal;
		end
		if (top_we) top_q <= top_d;
		if (res_we) begin
			res_top_q  <= res_top_d;
			res_st_q   <= res_st_d;
			res_done_q <= res_done_d;
		end
		if (out_load) begin
			out_top_q  <= res_top_q;
			out_st_q   <= res_st_q;
			out_done_q <= res_done_q;
		end
	end

	// stack memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) mem[cnt_m1[AW-1:0]] <= top_q;
		if (mem_re) rd_q <= mem[cnt_m2[AW-1:0]];
	end

	smev_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (top_q),
		.b      (rd_q),
		.rsp    (alu_rsp),
		.result (alu_res)
	);

	assign out_valid = out_valid_q;
	assign top_value = out_top_q;
	assign status    = out_st_q;
	assign done_res  = out_done_q;

	`SMEV_ASSERT(a_alu_in_calc, clk, arst_n, alu_rsp.busy |-> state_q == S_CALC, "alu busy outside calc")
	`SMEV_ASSERT(a_count_range, clk, arst_n, count_q <= CW'(STACK_DEPTH), "stack count beyond depth")
	`SMEV_ASSERT(a_done_ok, clk, arst_n, (out_valid && done_res) |-> status == ST_OK, "done with error status")
	`SMEV_ASSERT(a_end_empties, clk, arst_n, (state_q == S_EXEC && op_q == OP_END) |=> count_q == '0, "end left stack")
	`SMEV_ASSERT_LOW_IN_RST(a_rst_out, clk, arst_n, out_valid_q, "output valid in reset")

endmodule
`default_nettype wire

>>> hw/rtl/smev_alu.sv
`default_nettype none
module smev_alu (
	input  logic                            clk,
	input  logic                            arst_n,
	input  smev_pkg::alu_req_t              req,
	input  logic [smev_pkg::DATA_W-1:0]     a,
	input  logic [smev_pkg::DATA_W-1:0]     b,
	output smev_pkg::alu_rsp_t              rsp,
	output logic [smev_pkg::DATA_W-1:0]     result
);
	import smev_pkg::*;

	localparam int CNT_W = $clog2(DATA_W);

	logic              run_q, fin_q, done_q;
	alu_op_t           op_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] x_q, y_q, acc_q, rem_q, result_q;
	logic              c_q, qneg_q, rneg_q;

	logic              bb, sbit, cout;
	logic [DATA_W:0]   trial, diff;
	logic              ge;
	logic [DATA_W-1:0] mul_sum, fix_in, fix_out, abs_a, abs_b;
	logic              fix_neg, is_div;

	always_comb begin
		// serial add/sub, one bit per cycle
		bb      = y_q[0] ^ (op_q == ALU_SUB);
		sbit    = x_q[0] ^ bb ^ c_q;
		cout    = (x_q[0] & bb) | (c_q & (x_q[0] ^ bb));
		// shift-add multiply
		mul_sum = acc_q + (y_q[0] ? x_q : '0);
		// restoring divide, one quotient bit per cycle
		trial   = {rem_q, x_q[DATA_W-1]};
		diff    = trial - {1'b0, y_q};
		ge      = ~diff[DATA_W];
		// sign fix after divide
		fix_in  = (op_q == ALU_DIV) ? x_q : rem_q;
		fix_neg = (op_q == ALU_DIV) ? qneg_q : rneg_q;
		fix_out = fix_neg ? (~fix_in + DATA_W'(1)) : fix_in;
		abs_a   = a[DATA_W-1] ? (~a + DATA_W'(1)) : a;
		abs_b   = b[DATA_W-1] ? (~b + DATA_W'(1)) : b;
		is_div  = (req.op == ALU_DIV) || (req.op == ALU_MOD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !run_q && !fin_q) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !run_q && !fin_q) begin
			op_q   <= req.op;
			c_q    <= (req.op == ALU_SUB);
			acc_q  <= '0;
			rem_q  <= '0;
			x_q    <= is_div ? abs_a : a;
			y_q    <= is_div ? abs_b : b;
			qneg_q <= a[DATA_W-1] ^ b[DATA_W-1];
			rneg_q <= a[DATA_W-1];
		end else if (run_q) begin
			case (op_q)
				ALU_ADD, ALU_SUB: begin
					acc_q <= {sbit, acc_q[DATA_W-1:1]};
					x_q   <= {1'b0, x_q[DATA_W-1:1]};
					y_q   <= {1'b0, y_q[DATA_W-1:1]};
					c_q   <= cout;
				end
				ALU_MUL: begin
					acc_q <= mul_sum;
					x_q   <= {x_q[DATA_W-2:0], 1'b0};
					y_q   <= {1'b0, y_q[DATA_W-1:1]};
				end
				default: begin
					rem_q <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
					x_q   <= {x_q[DATA_W-2:0], ge};
				end
			endcase
		end else if (fin_q) begin
			result_q <= ((op_q == ALU_DIV) || (op_q == ALU_MOD)) ? fix_out : acc_q;
		end
	end

	assign rsp.busy = run_q | fin_q;
	assign rsp.done = done_q;
	assign result   = result_q;

endmodule
`default_nettype wire
